// ===== design/tksd_pkg.sv =====
// shared constants, event codes and control types for the terminal key sequence decoder
package tksd_pkg;

    // longest chunk that still decodes; position counter saturates at its top value
    localparam int MAX_CHUNK = 64;
    localparam int POS_W     = 7;
    localparam int CMP_W     = 10;
    localparam int NUM_W     = 16;

    // control bytes and sequence characters
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_U     = 8'h75;

    // key event codes
    localparam logic [5:0] EV_NONE          = 6'd0;
    localparam logic [5:0] EV_TAB           = 6'd1;
    localparam logic [5:0] EV_ENTER         = 6'd2;
    localparam logic [5:0] EV_ESC           = 6'd3;
    localparam logic [5:0] EV_BACKSPACE     = 6'd4;
    localparam logic [5:0] EV_CHAR          = 6'd5;
    localparam logic [5:0] EV_ALT_ENTER     = 6'd6;
    localparam logic [5:0] EV_ALT_BACKSPACE = 6'd7;
    localparam logic [5:0] EV_ALT_CHAR      = 6'd8;
    localparam logic [5:0] EV_MOUSE         = 6'd9;
    localparam logic [5:0] EV_ARROW         = 6'd10;
    localparam logic [5:0] EV_SHIFT_ARROW   = 6'd14;
    localparam logic [5:0] EV_ALT_ARROW     = 6'd18;
    localparam logic [5:0] EV_SH_ALT_ARROW  = 6'd22;
    localparam logic [5:0] EV_CTRL_ARROW    = 6'd26;
    localparam logic [5:0] EV_SH_CTRL_ARROW = 6'd30;
    localparam logic [5:0] EV_SHIFT_TAB     = 6'd34;

    // parameter field index values
    localparam logic [1:0] FLD_FIRST  = 2'd0;
    localparam logic [1:0] FLD_SECOND = 2'd1;
    localparam logic [1:0] FLD_EXTRA  = 2'd2;

    typedef struct packed {
        logic feed;
        logic clear;
    } tksd_param_ctl_t;

endpackage

// ===== design/terminal_key_sequence_decoder.sv =====
// top level of the terminal key sequence decoder
//
// usage:
//   slave channel (s_*) carries the bytes of one terminal read chunk, one byte
//   per transfer, s_tlast high on the last byte of the chunk
//   master channel (m_*) carries one key event per chunk, issued for the
//   transfer that carries s_tlast; bytes without s_tlast give no event
//   the event is registered: it appears on m_tvalid in the cycle after the last
//   byte is taken; throughput is one byte per cycle while s_tready is high, set by
//   the single decode pass between the chunk state registers and the output register
//   the output register parts the channels: s_tready stays high while the
//   output register is empty or being emptied in the same cycle, so a stalled
//   receiver holds back input only once an event is waiting
//   reset: async active low rst_n clears the chunk state (position, saved
//   bytes, csi parameters) and empties the output register
//   after each chunk end all chunk state returns to its reset value
//   mouse bytes not received read as a space, so their offsets are zero
module terminal_key_sequence_decoder
    import tksd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in[7:0]
    input  logic        s_tlast,   // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // event_res[5:0], char_code[13:6], pointer_x[21:14],
                                   // pointer_y[29:22], zero pad [31:30]
);

    // chunk state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       lead_reg, lead_next;
    logic [7:0]       second_reg, second_next;
    logic [7:0]       third_reg, third_next;
    logic [7:0]       btn_reg, btn_next;
    logic [7:0]       col_reg, col_next;
    logic [7:0]       row_reg, row_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       ev_reg, ev_next;
    logic [7:0]       ch_reg, ch_next;
    logic [7:0]       px_reg, px_next;
    logic [7:0]       py_reg, py_next;

    logic             take;
    logic             at_end;
    tksd_param_ctl_t  pctl;
    logic [NUM_W-1:0] modifier;

    // decode helpers
    logic [7:0]       third_eff, btn_eff, col_eff, row_eff;
    logic             too_long;
    logic             shift, alt, ctrl, is_arrow;
    logic [5:0]       arrow_off;
    logic [5:0]       csi_ev;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign at_end   = take && s_tlast;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, py_reg, px_reg, ch_reg, ev_reg};

    // parameters only come from bytes before the final one, from position 2 on
    assign pctl.feed  = take && !s_tlast && (pos_reg >= POS_W'(2));
    assign pctl.clear = at_end;

    tksd_param u_param (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pctl),
        .data     (s_tdata),
        .modifier (modifier)
    );

    // the final byte lands in its slot before decoding
    assign third_eff = (pos_reg == POS_W'(2)) ? s_tdata : third_reg;
    assign btn_eff   = (pos_reg == POS_W'(3)) ? s_tdata : btn_reg;
    assign col_eff   = (pos_reg == POS_W'(4)) ? s_tdata : col_reg;
    assign row_eff   = (pos_reg == POS_W'(5)) ? s_tdata : row_reg;

    assign too_long = {{(CMP_W-POS_W){1'b0}}, pos_reg} >= CMP_W'(MAX_CHUNK);

    // modifier bits: shift on even nonzero, alt on 3 or 4, ctrl from 5 up
    assign shift = (modifier != '0) && !modifier[0];
    assign alt   = (modifier == NUM_W'(3)) || (modifier == NUM_W'(4));
    assign ctrl  = modifier >= NUM_W'(5);

    always_comb
    begin
        is_arrow  = 1'b1;
        arrow_off = 6'd0;
        case (s_tdata)
            CH_A:    arrow_off = 6'd0;
            CH_B:    arrow_off = 6'd1;
            CH_D:    arrow_off = 6'd2;
            CH_C:    arrow_off = 6'd3;
            default: is_arrow  = 1'b0;
        endcase
    end

    always_comb
    begin
        csi_ev = EV_NONE;
        if (s_tdata == CH_TILDE || s_tdata == CH_U)
            csi_ev = EV_NONE;
        else if (is_arrow)
        begin
            if (alt)
                csi_ev = (shift ? EV_SH_ALT_ARROW : EV_ALT_ARROW) + arrow_off;
            else if (ctrl)
                csi_ev = (shift ? EV_SH_CTRL_ARROW : EV_CTRL_ARROW) + arrow_off;
            else if (shift)
                csi_ev = EV_SHIFT_ARROW + arrow_off;
            else
                csi_ev = EV_ARROW + arrow_off;
        end
        else if (s_tdata == CH_Z)
            csi_ev = EV_SHIFT_TAB;
    end

    // event decode for the last byte of a chunk
    always_comb
    begin
        ev_next = EV_NONE;
        ch_next = 8'd0;
        px_next = 8'd0;
        py_next = 8'd0;
        if (too_long)
            ev_next = EV_NONE;
        else if (pos_reg == '0)
        begin
            case (s_tdata)
                CH_TAB:  ev_next = EV_TAB;
                CH_CR:   ev_next = EV_ENTER;
                CH_ESC:  ev_next = EV_ESC;
                CH_DEL:  ev_next = EV_BACKSPACE;
                default:
                begin
                    ev_next = EV_CHAR;
                    ch_next = s_tdata;
                end
            endcase
        end
        else if (pos_reg == POS_W'(1) && lead_reg == CH_ESC)
        begin
            // control bytes after escape other than return and delete give nothing
            if (s_tdata == CH_CR)
                ev_next = EV_ALT_ENTER;
            else if (s_tdata == CH_DEL)
                ev_next = EV_ALT_BACKSPACE;
            else if (s_tdata >= CH_SPACE)
            begin
                ev_next = EV_ALT_CHAR;
                ch_next = s_tdata;
            end
        end
        else if (pos_reg >= POS_W'(2) && lead_reg == CH_ESC && second_reg == CH_LBRK)
        begin
            if (third_eff == CH_M)
            begin
                ev_next = EV_MOUSE;
                ch_next = btn_eff - CH_SPACE;
                px_next = col_eff - CH_SPACE;
                py_next = row_eff - CH_SPACE;
            end
            else
                ev_next = csi_ev;
        end
    end

    // chunk state update
    always_comb
    begin
        pos_next    = pos_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        third_next  = third_reg;
        btn_next    = btn_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (at_end)
        begin
            pos_next    = '0;
            lead_next   = 8'd0;
            second_next = 8'd0;
            third_next  = 8'd0;
            btn_next    = CH_SPACE;
            col_next    = CH_SPACE;
            row_next    = CH_SPACE;
        end
        else if (take)
        begin
            case (pos_reg)
                POS_W'(0): lead_next   = s_tdata;
                POS_W'(1): second_next = s_tdata;
                POS_W'(2): third_next  = s_tdata;
                POS_W'(3): btn_next    = s_tdata;
                POS_W'(4): col_next    = s_tdata;
                POS_W'(5): row_next    = s_tdata;
                default:   ;
            endcase
            // position saturates at its top value
            if (pos_reg != {POS_W{1'b1}})
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (at_end)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            lead_reg      <= 8'd0;
            second_reg    <= 8'd0;
            third_reg     <= 8'd0;
            btn_reg       <= CH_SPACE;
            col_reg       <= CH_SPACE;
            row_reg       <= CH_SPACE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            lead_reg      <= lead_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            btn_reg       <= btn_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // event payload, loaded only when a chunk ends
    always_ff @(posedge clk)
    begin
        if (at_end)
        begin
            ev_reg <= ev_next;
            ch_reg <= ch_next;
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

endmodule

// ===== design/tksd_param.sv =====
// csi decimal parameter accumulator with saturation and modifier select
module tksd_param
    import tksd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tksd_param_ctl_t        ctl,
    input  logic [7:0]             data,
    output logic [NUM_W-1:0]       modifier
);

    logic [NUM_W-1:0] first_number_reg, first_number_next;
    logic [NUM_W-1:0] second_number_reg, second_number_next;
    logic [1:0]       field_index_reg, field_index_next;
    logic             digits_ended_reg, digits_ended_next;

    logic             is_digit;
    logic [3:0]       digit;
    logic [NUM_W-1:0] acc;
    logic [NUM_W+3:0] acc_x10;
    logic [NUM_W-1:0] acc_sat;

    assign is_digit = (data >= CH_DIG0) && (data <= CH_DIG9);
    assign digit    = 4'(data - CH_DIG0);
    assign acc      = (field_index_reg == FLD_FIRST) ? first_number_reg : second_number_reg;
    assign acc_x10  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{NUM_W{1'b0}}, digit};
    assign acc_sat  = (acc_x10 > {4'd0, {NUM_W{1'b1}}}) ? {NUM_W{1'b1}} : acc_x10[NUM_W-1:0];

    assign modifier = (field_index_reg != FLD_FIRST) ? second_number_reg : first_number_reg;

    always_comb
    begin
        first_number_next  = first_number_reg;
        second_number_next = second_number_reg;
        field_index_next   = field_index_reg;
        digits_ended_next  = digits_ended_reg;
        if (ctl.clear)
        begin
            first_number_next  = '0;
            second_number_next = '0;
            field_index_next   = FLD_FIRST;
            digits_ended_next  = 1'b0;
        end
        else if (ctl.feed)
        begin
            if (data == CH_SEMI)
            begin
                if (field_index_reg == FLD_FIRST)
                begin
                    field_index_next  = FLD_SECOND;
                    digits_ended_next = 1'b0;
                end
                else
                begin
                    field_index_next = FLD_EXTRA;
                end
            end
            else if (field_index_reg == FLD_FIRST || field_index_reg == FLD_SECOND)
            begin
                if (!digits_ended_reg && is_digit)
                begin
                    if (field_index_reg == FLD_FIRST)
                        first_number_next = acc_sat;
                    else
                        second_number_next = acc_sat;
                end
                else
                begin
                    digits_ended_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_number_reg  <= '0;
            second_number_reg <= '0;
            field_index_reg   <= FLD_FIRST;
            digits_ended_reg  <= 1'b0;
        end
        else
        begin
            first_number_reg  <= first_number_next;
            second_number_reg <= second_number_next;
            field_index_reg   <= field_index_next;
            digits_ended_reg  <= digits_ended_next;
        end
    end

endmodule
